FILE: rtl/core/lru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

   // Store geometry
   localparam int FRAMES        = 8;
   localparam int PAGE_BITS     = 8;
   localparam int COUNT_BITS    = 16;
   localparam int SLOT_BITS     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_BITS     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int LIMIT_BITS    = RANK_BITS + 1;

   // Port widths fixed by the interface
   localparam int REQ_PAGE_BITS = 8;
   localparam int RSP_SLOT_BITS = 3;
   localparam int RSP_CNT_BITS  = 16;
   localparam int CFG_BITS      = 4;

   localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(8);
   localparam logic [RANK_BITS-1:0]  RANK_MAX  = RANK_BITS'(FRAMES - 1);
   localparam logic [LIMIT_BITS-1:0] LIMIT_ALL = LIMIT_BITS'(FRAMES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_COMMIT
   } lru_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture request beat
      logic decide;   // register hit / slot / rank limit
      logic commit;   // update frames, ranks, totals, result
   } lru_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/lru_page_replacement.sv
// LRU page frame store, fully associative over up to eight frames.
// Request: drive req_page and req_end_of_string with start high; the beat
// is taken at a rising edge where start is high and busy is low.
// Result: rsp_valid is high for exactly one cycle with rsp_hit, rsp_slot,
// rsp_hits_total, rsp_faults_total and rsp_run_done; the receiver cannot
// stall, so the result must be taken in that cycle.
// busy is high only in the compare cycle (ST_DECIDE), when the frames
// are searched for a match, an empty frame and the oldest rank; ranks,
// frames, totals and the result registers update in the next cycle
// (ST_COMMIT), in which a new request may already be accepted.
// Configuration: csr_valid/csr_ready write frames_in_use (csr_ready is
// always high); write only while no request is in flight.
// Reset (synchronous, active high): all frames empty, ranks and totals
// zero, frames_in_use = 8. A request with end_of_string set clears the
// frames and totals after its result.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [lru_pkg::REQ_PAGE_BITS-1:0]   req_page,
   input  wire logic                                req_end_of_string,
   output logic                                     rsp_valid,
   output logic                                     rsp_hit,
   output logic [lru_pkg::RSP_SLOT_BITS-1:0]        rsp_slot,
   output logic [lru_pkg::RSP_CNT_BITS-1:0]         rsp_hits_total,
   output logic [lru_pkg::RSP_CNT_BITS-1:0]         rsp_faults_total,
   output logic                                     rsp_run_done,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lru_pkg::CFG_BITS-1:0]        csr_data
);
   import lru_pkg::*;

   lru_cmd_type cmd;

   assign csr_ready = 1'b1;

   lru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lru_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_page          (req_page),
      .req_end_of_string (req_end_of_string),
      .csr_valid         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .rsp_hit           (rsp_hit),
      .rsp_slot          (rsp_slot),
      .rsp_hits_total    (rsp_hits_total),
      .rsp_faults_total  (rsp_faults_total),
      .rsp_run_done      (rsp_run_done)
   );

endmodule

`default_nettype wire

FILE: rtl/core/lru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   output lru_pkg::lru_cmd_type     cmd
);
   import lru_pkg::*;

   lru_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   // Accept in idle and in the commit cycle; decide reads the updated store
   assign busy   = (state_ff == ST_DECIDE);
   assign accept = start && !busy;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_COMMIT;
         ST_COMMIT: state_in = accept ? ST_DECIDE : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE:   ;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_COMMIT: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lru_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lru_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lru_pkg::lru_cmd_type                cmd,
   input  wire logic [lru_pkg::REQ_PAGE_BITS-1:0]   req_page,
   input  wire logic                                req_end_of_string,
   input  wire logic                                csr_valid,
   input  wire logic [lru_pkg::CFG_BITS-1:0]        csr_data,
   output logic                                     rsp_hit,
   output logic [lru_pkg::RSP_SLOT_BITS-1:0]        rsp_slot,
   output logic [lru_pkg::RSP_CNT_BITS-1:0]         rsp_hits_total,
   output logic [lru_pkg::RSP_CNT_BITS-1:0]         rsp_faults_total,
   output logic                                     rsp_run_done
);
   import lru_pkg::*;

   // Configuration and request registers
   logic [CFG_BITS-1:0]   cfg_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  last_ff;

   // Frame store
   logic [PAGE_BITS-1:0]  frame_page_ff [FRAMES];
   logic [FRAMES-1:0]     frame_valid_ff;
   logic [RANK_BITS-1:0]  rank_ff       [FRAMES];
   logic [COUNT_BITS-1:0] hit_count_ff, fault_count_ff;

   // Decision registers
   logic                  hit_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   // Result registers
   logic                  out_hit_ff, out_last_ff;
   logic [SLOT_BITS-1:0]  out_slot_ff;
   logic [COUNT_BITS-1:0] out_hits_ff, out_faults_ff;

   logic [CFG_BITS-1:0]   cfg_eff;
   logic [FRAMES-1:0]     active;
   logic                  match_found, empty_found;
   logic [SLOT_BITS-1:0]  match_idx, empty_idx, victim_idx;
   logic [RANK_BITS-1:0]  victim_rank;
   logic                  dec_hit;
   logic [SLOT_BITS-1:0]  dec_slot;
   logic [LIMIT_BITS-1:0] dec_limit;
   logic [COUNT_BITS-1:0] hit_count_in, fault_count_in;

   // Frames taking part: zero counts as one, above FRAMES clamps naturally
   assign cfg_eff = (cfg_ff == '0) ? CFG_BITS'(1) : cfg_ff;
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         active[i] = (i < int'(cfg_eff));
      end
   end

   // Lowest matching frame and lowest empty frame
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      empty_found = 1'b0;
      empty_idx   = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (active[i] && frame_valid_ff[i] && frame_page_ff[i] == page_ff) begin
            match_found = 1'b1;
            match_idx   = SLOT_BITS'(i);
         end
         if (active[i] && !frame_valid_ff[i]) begin
            empty_found = 1'b1;
            empty_idx   = SLOT_BITS'(i);
         end
      end
   end

   // Oldest frame, lowest index on ties
   always_comb begin
      victim_idx  = '0;
      victim_rank = rank_ff[0];
      for (int i = 1; i < FRAMES; i++) begin
         if (active[i] && rank_ff[i] > victim_rank) begin
            victim_idx  = SLOT_BITS'(i);
            victim_rank = rank_ff[i];
         end
      end
   end

   // Slot and aging limit: a fill ages every active valid frame
   always_comb begin
      if (match_found) begin
         dec_hit   = 1'b1;
         dec_slot  = match_idx;
         dec_limit = {1'b0, rank_ff[match_idx]};
      end else if (empty_found) begin
         dec_hit   = 1'b0;
         dec_slot  = empty_idx;
         dec_limit = LIMIT_ALL;
      end else begin
         dec_hit   = 1'b0;
         dec_slot  = victim_idx;
         dec_limit = {1'b0, victim_rank};
      end
   end

   // Saturating totals including this beat
   always_comb begin
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      if (hit_ff) begin
         if (hit_count_ff != COUNT_MAX) hit_count_in = hit_count_ff + COUNT_BITS'(1);
      end else begin
         if (fault_count_ff != COUNT_MAX) fault_count_in = fault_count_ff + COUNT_BITS'(1);
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         cfg_ff <= csr_data;
      end
   end

   // Request and decision capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_page[PAGE_BITS-1:0];
         last_ff <= req_end_of_string;
      end
      if (cmd.decide) begin
         hit_ff   <= dec_hit;
         slot_ff  <= dec_slot;
         limit_ff <= dec_limit;
      end
   end

   // Page contents: written on a fault
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) begin
         frame_page_ff[slot_ff] <= page_ff;
      end
   end

   // Valid bits, ranks and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         if (last_ff) begin
            frame_valid_ff <= '0;
            hit_count_ff   <= '0;
            fault_count_ff <= '0;
            for (int i = 0; i < FRAMES; i++) begin
               rank_ff[i] <= '0;
            end
         end else begin
            hit_count_ff   <= hit_count_in;
            fault_count_ff <= fault_count_in;
            for (int i = 0; i < FRAMES; i++) begin
               if (SLOT_BITS'(i) == slot_ff) begin
                  rank_ff[i]        <= '0;
                  frame_valid_ff[i] <= 1'b1;
               end else if (active[i] && frame_valid_ff[i] &&
                            {1'b0, rank_ff[i]} < limit_ff && rank_ff[i] < RANK_MAX) begin
                  rank_ff[i] <= rank_ff[i] + RANK_BITS'(1);
               end
            end
         end
      end
   end

   // Result beat
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_hit_ff    <= hit_ff;
         out_slot_ff   <= slot_ff;
         out_hits_ff   <= hit_count_in;
         out_faults_ff <= fault_count_in;
         out_last_ff   <= last_ff;
      end
   end

   assign rsp_hit          = out_hit_ff;
   assign rsp_slot         = RSP_SLOT_BITS'(out_slot_ff);
   assign rsp_hits_total   = RSP_CNT_BITS'(out_hits_ff);
   assign rsp_faults_total = RSP_CNT_BITS'(out_faults_ff);
   assign rsp_run_done     = out_last_ff;

endmodule

`default_nettype wire
